// ===== design/vbp_pkg.sv =====
// Package for the volume block pooling block: widths, register indexes,
// reduction modes, the per-axis status struct and config clamp functions.
// No dependencies.
package vbp_pkg;

  localparam int MAX_DIM    = 64;
  localparam int MAX_FACTOR = 16;
  localparam int DIM_W      = $clog2(MAX_DIM);
  localparam int SIZE_W     = 7;
  localparam int FACTOR_W   = 5;
  localparam int MODE_W     = 2;
  localparam int SAMPLE_W   = 32;
  localparam int VALUE_W    = 48;
  localparam int ADDR_W     = 2 * DIM_W;
  localparam int SPAN_W     = DIM_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [MODE_W-1:0] MODE_MAX    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ABSMAX = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X   = 3'd0,
    REG_SIZE_Y   = 3'd1,
    REG_SIZE_Z   = 3'd2,
    REG_FACTOR_X = 3'd3,
    REG_FACTOR_Y = 3'd4,
    REG_FACTOR_Z = 3'd5,
    REG_MODE     = 3'd6
  } reg_e;

  typedef logic [SIZE_W-1:0]   dim_t;
  typedef logic [FACTOR_W-1:0] fac_t;

  typedef struct packed {
    logic [DIM_W-1:0] bidx;
    logic             in_range;
    logic             first;
    logic             last_off;
    logic             last_blk;
  } axis_t;

  function automatic dim_t eff_size(input dim_t s);
    dim_t r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(MAX_DIM)) begin
      r = SIZE_W'(MAX_DIM);
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic fac_t eff_factor(input fac_t f);
    fac_t r;
    if (f == '0) begin
      r = FACTOR_W'(1);
    end else if (f > FACTOR_W'(MAX_FACTOR)) begin
      r = FACTOR_W'(MAX_FACTOR);
    end else begin
      r = f;
    end
    return r;
  endfunction

endpackage

// ===== design/vbp_axis.sv =====
// Position tracker for one axis: sample position, offset inside the block,
// block start and block index, with range and block-edge status.
// Depends on vbp_pkg.
module vbp_axis import vbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  clear_i,
  input  logic  step_i,
  input  dim_t  size_i,
  input  fac_t  factor_i,
  output logic  wrap_o,
  output axis_t stat_o
);

  logic [DIM_W-1:0]    pos_q, bstart_q, bidx_q;
  logic [FACTOR_W-1:0] off_q;
  logic [SIZE_W-1:0]   pos_inc;
  logic [FACTOR_W-1:0] off_inc;
  logic [SPAN_W-1:0]   span, span2;

  assign pos_inc = SIZE_W'(pos_q) + SIZE_W'(1);
  assign off_inc = off_q + FACTOR_W'(1);
  assign wrap_o  = pos_inc >= size_i;
  assign span    = SPAN_W'(bstart_q) + SPAN_W'(factor_i);
  assign span2   = span + SPAN_W'(factor_i);

  assign stat_o.bidx     = bidx_q;
  assign stat_o.in_range = span <= SPAN_W'(size_i);
  assign stat_o.first    = off_q == '0;
  assign stat_o.last_off = off_inc == factor_i;
  assign stat_o.last_blk = span2 > SPAN_W'(size_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      off_q    <= '0;
      bstart_q <= '0;
      bidx_q   <= '0;
    end else if (clear_i || (step_i && wrap_o)) begin
      pos_q    <= '0;
      off_q    <= '0;
      bstart_q <= '0;
      bidx_q   <= '0;
    end else if (step_i) begin
      pos_q <= pos_inc[DIM_W-1:0];
      if (off_inc == factor_i) begin
        off_q    <= '0;
        bstart_q <= bstart_q + DIM_W'(factor_i);
        bidx_q   <= bidx_q + DIM_W'(1);
      end else begin
        off_q <= off_inc;
      end
    end
  end

endmodule

// ===== design/vbp_acc_mem.sv =====
// Block accumulator memory: one write port, one read port, registered read.
// Depends on vbp_pkg.
module vbp_acc_mem import vbp_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  logic [VALUE_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output logic [VALUE_W-1:0] rdata_o
);

  logic [VALUE_W-1:0] mem [MAX_DIM*MAX_DIM];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/volume_block_pooling.sv =====
// Top level of the volume block pooling block.
// Depends on vbp_pkg, vbp_axis and vbp_acc_mem.
//
// Samples arrive x slowest, z fastest, one transaction per cycle when not
// stalled, with no gaps needed: each sample does one read-modify-write of the
// block accumulator in a 4096-entry memory, read on acceptance and written back
// from the stage-1 register, with the last write forwarded to cover the
// read-write overlap. A result passes through the stage-1 and output registers
// after the sample that completes its block; the output register holds it while
// the sink stalls, and input stall rises only when that register is full,
// stalled, and another result is ready. Samples past the last whole block on
// any axis are counted but ignored. Configuration writes take effect at once
// and restart the field at the origin; issue them only while the block is idle.
module volume_block_pooling import vbp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [VALUE_W-1:0]  block_value_o,
  output logic [DIM_W-1:0]           out_x_o,
  output logic [DIM_W-1:0]           out_y_o,
  output logic [DIM_W-1:0]           out_z_o,
  output logic                       last_block_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  dim_t              size_x_q, size_y_q, size_z_q;
  fac_t              factor_x_q, factor_y_q, factor_z_q;
  logic [MODE_W-1:0] mode_q;
  logic              cfg_hit;

  axis_t ax, ay, az;
  logic  wrap_x, wrap_y, wrap_z;
  logic  accept, step_y, step_x;
  logic  in_range;

  logic                       s1_valid_q, s1_first_q, s1_emit_q, s1_last_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic [ADDR_W-1:0]          s1_addr_q;
  logic [DIM_W-1:0]           s1_bx_q, s1_by_q, s1_bz_q;
  logic                       s1_adv;

  logic                       fwd_valid_q;
  logic [ADDR_W-1:0]          fwd_addr_q;
  logic signed [VALUE_W-1:0]  fwd_data_q;

  logic [ADDR_W-1:0]          raddr;
  logic [VALUE_W-1:0]         rdata;
  logic signed [VALUE_W-1:0]  base, s_ext, s_abs, acc_new;
  logic signed [VALUE_W:0]    sum;

  logic                       mem_we;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z,
        REG_FACTOR_X, REG_FACTOR_Y, REG_FACTOR_Z, REG_MODE: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q   <= SIZE_W'(MAX_DIM);
      size_y_q   <= SIZE_W'(MAX_DIM);
      size_z_q   <= SIZE_W'(MAX_DIM);
      factor_x_q <= FACTOR_W'(2);
      factor_y_q <= FACTOR_W'(2);
      factor_z_q <= FACTOR_W'(2);
      mode_q     <= MODE_MAX;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_SIZE_X:   size_x_q   <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Y:   size_y_q   <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Z:   size_z_q   <= cfg_data_i[SIZE_W-1:0];
        REG_FACTOR_X: factor_x_q <= cfg_data_i[FACTOR_W-1:0];
        REG_FACTOR_Y: factor_y_q <= cfg_data_i[FACTOR_W-1:0];
        REG_FACTOR_Z: factor_z_q <= cfg_data_i[FACTOR_W-1:0];
        REG_MODE:     mode_q     <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv     = !(s1_valid_q && s1_emit_q && out_valid_o && out_stall_i);
  assign in_stall_o = !s1_adv;
  assign accept     = in_valid_i && s1_adv;
  assign step_y     = accept && wrap_z;
  assign step_x     = step_y && wrap_y;

  vbp_axis u_axis_x (
    .clk_i, .rst_ni, .clear_i(cfg_hit), .step_i(step_x),
    .size_i(eff_size(size_x_q)), .factor_i(eff_factor(factor_x_q)),
    .wrap_o(wrap_x), .stat_o(ax)
  );

  vbp_axis u_axis_y (
    .clk_i, .rst_ni, .clear_i(cfg_hit), .step_i(step_y),
    .size_i(eff_size(size_y_q)), .factor_i(eff_factor(factor_y_q)),
    .wrap_o(wrap_y), .stat_o(ay)
  );

  vbp_axis u_axis_z (
    .clk_i, .rst_ni, .clear_i(cfg_hit), .step_i(accept),
    .size_i(eff_size(size_z_q)), .factor_i(eff_factor(factor_z_q)),
    .wrap_o(wrap_z), .stat_o(az)
  );

  assign in_range = ax.in_range && ay.in_range && az.in_range;
  assign raddr    = {ay.bidx, az.bidx};
  assign mem_we   = s1_valid_q && s1_adv;

  vbp_acc_mem u_acc_mem (
    .clk_i,
    .we_i   (mem_we),
    .waddr_i(s1_addr_q),
    .wdata_i(acc_new),
    .re_i   (accept),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= in_range;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= sample_i;
      s1_addr_q   <= raddr;
      s1_first_q  <= ax.first && ay.first && az.first;
      s1_emit_q   <= ax.last_off && ay.last_off && az.last_off;
      s1_last_q   <= ax.last_blk && ay.last_blk && az.last_blk;
      s1_bx_q     <= ax.bidx;
      s1_by_q     <= ay.bidx;
      s1_bz_q     <= az.bidx;
    end
  end

  always_comb begin
    if (s1_first_q) begin
      base = '0;
    end else if (fwd_valid_q && fwd_addr_q == s1_addr_q) begin
      base = fwd_data_q;
    end else begin
      base = rdata;
    end
    s_ext = {{(VALUE_W-SAMPLE_W){s1_sample_q[SAMPLE_W-1]}}, s1_sample_q};
    s_abs = s_ext[VALUE_W-1] ? -s_ext : s_ext;
    sum   = {base[VALUE_W-1], base} + {s_ext[VALUE_W-1], s_ext};
    unique case (mode_q)
      MODE_MAX:    acc_new = (s_ext > base) ? s_ext : base;
      MODE_ABSMAX: acc_new = (s_abs > base) ? s_abs : base;
      default: begin
        if (sum[VALUE_W] != sum[VALUE_W-1]) begin
          acc_new = sum[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                 : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
          acc_new = sum[VALUE_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (mem_we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (mem_we && s1_emit_q) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && s1_emit_q) begin
      block_value_o <= acc_new;
      out_x_o       <= s1_bx_q;
      out_y_o       <= s1_by_q;
      out_z_o       <= s1_bz_q;
      last_block_o  <= s1_last_q;
    end
  end

endmodule
